// ----- rtl/ppp_frame_receiver_destuff_checksum_defines.svh -----
// Assertion macros shared by the PPP frame receiver RTL.
`ifndef PPP_FRAME_RECEIVER_DESTUFF_CHECKSUM_DEFINES_SVH
`define PPP_FRAME_RECEIVER_DESTUFF_CHECKSUM_DEFINES_SVH

// Check that a condition implies another one in the same cycle.
`define PFR_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("same-cycle implication failed");

// Check that a condition implies another one in the next cycle.
`define PFR_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle implication failed");

`endif

// ----- rtl/pppfr_pkg.sv -----
// Types, constants and the checksum adder of the PPP frame receiver.
`default_nettype none

package pppfr_pkg;

   localparam logic [7:0]  ESCAPE_RESET = 8'b01111101;
   localparam logic [15:0] SUM_GOOD     = 16'hFFFF;
   localparam int          WORD_BITS    = 16;

   // One result item.
   typedef struct packed {
      logic [7:0]           out_byte;
      logic                 frame_end;
      logic                 frame_valid;
      logic [WORD_BITS-1:0] folded_sum;
   } rsp_type;

   // Add a word with end-around carry.
   function automatic logic [WORD_BITS-1:0] ones_add(
      input logic [WORD_BITS-1:0] acc,
      input logic [WORD_BITS-1:0] word
   );
      logic [WORD_BITS:0] total;
      total = {1'b0, acc} + {1'b0, word};
      return total[WORD_BITS-1:0] + {{(WORD_BITS-1){1'b0}}, total[WORD_BITS]};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ppp_frame_receiver_destuff_checksum.sv -----
// PPP frame receiver: flag stripping, byte destuffing and ones' complement checksum.
// A result item is registered into the rsp output register, or into the skid register while rsp is stalled.
// One item is accepted per cycle while req_stall is low; the frame state updates in the cycle of acceptance.
// req_stall rises only while the skid register holds an item behind a stalled rsp.
// Reset (synchronous, active high) clears the frame control state (not the held
// bytes) and both output slots, and sets the escape value to 125.
`default_nettype none
`include "ppp_frame_receiver_destuff_checksum_defines.svh"

module ppp_frame_receiver_destuff_checksum (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_frame_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_frame_end,
   output logic             rsp_frame_valid,
   output logic [15:0]      rsp_folded_sum
);

   // Configuration
   logic [7:0]  escape_ff, escape_in;

   // Frame state
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        seen_opening_ff, seen_opening_in;
   logic        escape_pending_ff, escape_pending_in;
   logic        stopped_ff, stopped_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  high_half_ff, high_half_in;
   logic        half_pending_ff, half_pending_in;
   logic [1:0]  middle_count_ff, middle_count_in;

   // Output register and skid slot
   logic                  rsp_valid_ff, rsp_valid_in;
   pppfr_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   pppfr_pkg::rsp_type    skid_data_ff, skid_data_in;

   logic                  accept;
   logic                  out_free;
   logic                  has_result;
   pppfr_pkg::rsp_type    result;
   logic [7:0]            leaving;
   logic [15:0]           folded;
   logic                  frame_idle;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Advance the frame state for one accepted item
   always_comb begin
      held0_in          = held0_ff;
      held1_in          = held1_ff;
      held_count_in     = held_count_ff;
      seen_opening_in   = seen_opening_ff;
      escape_pending_in = escape_pending_ff;
      stopped_in        = stopped_ff;
      sum_in            = sum_ff;
      high_half_in      = high_half_ff;
      half_pending_in   = half_pending_ff;
      middle_count_in   = middle_count_ff;
      has_result        = 1'b0;
      result            = '0;
      leaving           = held0_ff;
      folded            = sum_ff;

      if (half_pending_ff) begin
         folded = pppfr_pkg::ones_add(sum_ff, {high_half_ff, 8'h00});
      end

      if (req_frame_last) begin
         // Report the folded sum and clear the frame
         has_result         = 1'b1;
         result.frame_end   = 1'b1;
         result.folded_sum  = folded;
         result.frame_valid = seen_opening_ff && (middle_count_ff >= 2'd2)
                              && (folded == pppfr_pkg::SUM_GOOD);
         held_count_in      = '0;
         seen_opening_in    = 1'b0;
         escape_pending_in  = 1'b0;
         stopped_in         = 1'b0;
         sum_in             = '0;
         high_half_in       = '0;
         half_pending_in    = 1'b0;
         middle_count_in    = '0;
      end else if (!seen_opening_ff) begin
         // Drop the opening flag
         seen_opening_in = 1'b1;
      end else begin
         // Pair bytes into words and add
         if (half_pending_ff) begin
            sum_in          = pppfr_pkg::ones_add(sum_ff, {high_half_ff, req_frame_byte});
            half_pending_in = 1'b0;
            high_half_in    = '0;
         end else begin
            high_half_in    = req_frame_byte;
            half_pending_in = 1'b1;
         end
         if (middle_count_ff != 2'd3) begin
            middle_count_in = middle_count_ff + 2'd1;
         end

         // Shift the two-byte delay and destuff the byte that leaves it
         if (held_count_ff == 2'd2) begin
            held0_in = held1_ff;
            held1_in = req_frame_byte;
            if (!stopped_ff) begin
               if (!escape_pending_ff && leaving == escape_ff) begin
                  escape_pending_in = 1'b1;
               end else begin
                  escape_pending_in = 1'b0;
                  if (leaving == 8'h00) begin
                     stopped_in = 1'b1;
                  end else begin
                     has_result      = 1'b1;
                     result.out_byte = leaving;
                  end
               end
            end
         end else begin
            if (held_count_ff[0]) begin
               held1_in = req_frame_byte;
            end else begin
               held0_in = req_frame_byte;
            end
            held_count_in = held_count_ff + 2'd1;
         end
      end
   end

   // Steer results into the output register or the skid slot
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept && has_result) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end else if (accept && has_result) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   assign escape_in = csr_wr_en ? csr_wr_data : escape_ff;

   // Control and frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff         <= pppfr_pkg::ESCAPE_RESET;
         held_count_ff     <= '0;
         seen_opening_ff   <= 1'b0;
         escape_pending_ff <= 1'b0;
         stopped_ff        <= 1'b0;
         sum_ff            <= '0;
         high_half_ff      <= '0;
         half_pending_ff   <= 1'b0;
         middle_count_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         escape_ff     <= escape_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (accept) begin
            held_count_ff     <= held_count_in;
            seen_opening_ff   <= seen_opening_in;
            escape_pending_ff <= escape_pending_in;
            stopped_ff        <= stopped_in;
            sum_ff            <= sum_in;
            high_half_ff      <= high_half_in;
            half_pending_ff   <= half_pending_in;
            middle_count_ff   <= middle_count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_data_ff.out_byte;
   assign rsp_frame_end   = rsp_data_ff.frame_end;
   assign rsp_frame_valid = rsp_data_ff.frame_valid;
   assign rsp_folded_sum  = rsp_data_ff.folded_sum;

   // Frame state sits at its cleared value
   assign frame_idle = (held_count_ff == 2'd0) && !seen_opening_ff && !half_pending_ff;

   // Skid slot only fills behind a held output item
   `PFR_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // Delay never counts past two bytes
   `PFR_ASSERT_IMPLIES(a_held_count_range, clock, reset, 1'b1, held_count_ff != 2'd3)
   // Closing flag clears the frame state
   `PFR_ASSERT_NEXT(a_frame_clear, clock, reset, accept && req_frame_last, frame_idle)

endmodule

`default_nettype wire
